/* rtl/core/obm_pkg.sv */
`timescale 1ns / 1ps
package obm_pkg;
    localparam int unsigned PRICE_W = 32;
    localparam int unsigned QTY_W   = 32;
    localparam int unsigned LEVEL_W = PRICE_W + QTY_W;
    localparam int unsigned COST_W  = 64;

    // bits of a sequencer state code
    localparam int unsigned STATE_W = 3;

    // one result beat, from the walk unit to the output register
    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              overflow;
    } t_result;
endpackage

/* rtl/core/order_book_merge_and_fill_cost.sv */
`timescale 1ns / 1ps
// one side of a price-level book, merged snapshot by snapshot
// s_axis: one beat per level update; tlast closes the snapshot and carries
//   the share count to buy against the new book
// m_axis: one beat per snapshot (on tlast) with the fill cost, the running
//   xor of all costs and the dropped-level flag
// the old book sits in one ram bank and the merge writes the other bank;
//   banks swap after each snapshot
// an update beat steps through the read, wait and compare states for each
//   old level copied ahead of it, then for the compare at its price, or is
//   placed from the read state when no old level is left; a beat without
//   an update that is not tlast goes back to idle from the read state
// the tlast beat also copies the remaining old levels, then walks the new
//   book through read, wait and step states per level into one shared
//   multiply-accumulate, then a drain state; ram read latency needs the waits
// s_axis_tready is high only while the sequencer is idle and no result
//   waits in the output register; a stalled m_axis holds its beat
// reset clears counters, bank select, xor and the flag; no ram clearing
//   pass is needed since only written entries are ever read
module order_book_merge_and_fill_cost
    import obm_pkg::*;
#(
    parameter int unsigned BOOK_DEPTH = 512
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // level_valid[0], price[32:1], quantity[64:33], shares[96:65], zero pad
    input  logic [103:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // cost[63:0], xor_total[127:64]
    output logic [127:0] m_axis_tdata,
    // overflow
    output logic         m_axis_tuser
);
    localparam int unsigned ADDR_W = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(BOOK_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BOOK_DEPTH);

    localparam logic [STATE_W-1:0] S_IDLE  = 3'd0;
    localparam logic [STATE_W-1:0] S_RD    = 3'd1; // issue old read
    localparam logic [STATE_W-1:0] S_WT    = 3'd2; // ram latency
    localparam logic [STATE_W-1:0] S_CMP   = 3'd3; // compare and copy
    localparam logic [STATE_W-1:0] S_WRD   = 3'd4; // walk read
    localparam logic [STATE_W-1:0] S_WWT   = 3'd5;
    localparam logic [STATE_W-1:0] S_WSTEP = 3'd6;
    localparam logic [STATE_W-1:0] S_DONE  = 3'd7; // let the mac drain

    logic [STATE_W-1:0] r_state, n_state;
    logic               r_bank;
    logic [CNT_W-1:0]   r_old_cnt, r_new_cnt, r_rd_idx, r_walk;
    logic               r_ovf;
    logic [COST_W-1:0]  r_xor;
    logic               r_valid, r_last;
    logic [PRICE_W-1:0] r_price;
    logic [QTY_W-1:0]   r_qty, r_rem;
    logic               r_out_v;
    t_result            r_res;
    logic               r_stop;

    // ram ports
    logic               we_a, we_b;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [LEVEL_W-1:0] wdata, rd_a, rd_b, rd_old, rd_new;
    logic               mac_clr, mac_en;
    logic [QTY_W-1:0]   mac_mult;
    logic [COST_W-1:0]  acc;
    logic               do_put;
    logic [PRICE_W-1:0] lv_price;
    logic [QTY_W-1:0]   lv_qty;

    obm_ram #(.WIDTH(LEVEL_W), .DEPTH(BOOK_DEPTH)) u_bank_a (
        .i_clk(i_clk), .i_we(we_a), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rd_a)
    );
    obm_ram #(.WIDTH(LEVEL_W), .DEPTH(BOOK_DEPTH)) u_bank_b (
        .i_clk(i_clk), .i_we(we_b), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rd_b)
    );
    obm_mac u_mac (
        .i_clk(i_clk), .i_clr(mac_clr), .i_en(mac_en), .i_mult(mac_mult),
        .i_price(lv_price), .o_acc(acc)
    );

    assign rd_old = r_bank ? rd_b : rd_a;
    assign rd_new = r_bank ? rd_a : rd_b;

    assign s_axis_tready = (r_state == S_IDLE) && !r_out_v;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {r_xor, r_res.cost};
    assign m_axis_tuser  = r_res.overflow;

    logic acc_in;
    assign acc_in = s_axis_tvalid && s_axis_tready;

    logic old_left;
    assign old_left = (r_rd_idx < r_old_cnt);

    // read address: old bank at the merge pointer, new bank in the walk
    assign raddr = (r_state == S_WRD || r_state == S_WWT || r_state == S_WSTEP)
                 ? ADDR_W'(r_walk) : ADDR_W'(r_rd_idx);
    assign lv_price = (r_state == S_WSTEP) ? rd_new[LEVEL_W-1:QTY_W] : '0;
    assign lv_qty   = rd_new[QTY_W-1:0];

    // merge write decision in S_CMP
    logic cmp_copy, cmp_eq, cmp_upd;
    always_comb begin
        cmp_copy = 1'b0;
        cmp_eq   = 1'b0;
        cmp_upd  = 1'b0;
        wdata    = {r_price, r_qty};
        if (r_state == S_CMP) begin
            if (!r_valid) begin
                cmp_copy = 1'b1;
            end else if (rd_old[LEVEL_W-1:QTY_W] < r_price) begin
                cmp_copy = 1'b1;
            end else begin
                cmp_eq  = (rd_old[LEVEL_W-1:QTY_W] == r_price);
                cmp_upd = (r_qty != '0);
            end
            if (cmp_copy) begin
                wdata = rd_old;
            end
        end
    end

    // an update with no old level left skips the compare
    logic idle_upd;
    assign idle_upd = (r_state == S_RD) && r_valid && !old_left && (r_qty != '0);

    assign do_put = cmp_copy || cmp_upd || idle_upd;
    assign waddr  = ADDR_W'(r_new_cnt);
    assign we_a   = do_put && (r_new_cnt < DEPTH_C) && r_bank;
    assign we_b   = do_put && (r_new_cnt < DEPTH_C) && !r_bank;

    // walk step
    logic walk_fit;
    assign walk_fit = (r_rem >= lv_qty);
    assign mac_clr  = acc_in;
    assign mac_en   = (r_state == S_WSTEP) && !r_stop;
    assign mac_mult = walk_fit ? lv_qty : r_rem;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (acc_in) n_state = S_RD;
            S_RD: begin
                // a beat without update only copies when it closes the snapshot
                if (old_left && (r_valid || r_last)) n_state = S_WT;
                else if (r_last) n_state = S_WRD;
                else n_state = S_IDLE;
            end
            S_WT:    n_state = S_CMP;
            S_CMP: begin
                if (cmp_copy) n_state = S_RD;
                else if (r_last) n_state = S_RD;
                else n_state = S_IDLE;
            end
            S_WRD:   n_state = (r_walk < r_new_cnt && !r_stop) ? S_WWT : S_DONE;
            S_WWT:   n_state = S_WSTEP;
            S_WSTEP: n_state = S_WRD;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bank    <= 1'b0;
            r_old_cnt <= '0;
            r_new_cnt <= '0;
            r_rd_idx  <= '0;
            r_walk    <= '0;
            r_ovf     <= 1'b0;
            r_xor     <= '0;
            r_out_v   <= 1'b0;
            r_stop    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_v && m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            if (acc_in) begin
                r_valid <= s_axis_tdata[0];
                r_price <= s_axis_tdata[32:1];
                r_qty   <= s_axis_tdata[64:33];
                r_rem   <= s_axis_tdata[96:65];
                r_last  <= s_axis_tlast;
                r_walk  <= '0;
                r_stop  <= 1'b0;
            end
            if (do_put) begin
                if (r_new_cnt < DEPTH_C) r_new_cnt <= r_new_cnt + 1'b1;
                else r_ovf <= 1'b1;
            end
            if (cmp_copy || cmp_eq) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            // after the update is placed the rest is a plain copy
            if (r_state == S_CMP && !cmp_copy) begin
                r_valid <= 1'b0;
            end
            if (idle_upd) begin
                r_valid <= 1'b0;
            end
            if (r_state == S_WSTEP) begin
                if (walk_fit) r_rem <= r_rem - lv_qty;
                else r_stop <= 1'b1;
                r_walk <= r_walk + 1'b1;
            end
            if (r_state == S_DONE) begin
                r_res.cost     <= acc;
                r_res.overflow <= r_ovf;
                r_xor     <= r_xor ^ acc;
                r_out_v   <= 1'b1;
                r_bank    <= ~r_bank;
                r_old_cnt <= r_new_cnt;
                r_new_cnt <= '0;
                r_rd_idx  <= '0;
                r_ovf     <= 1'b0;
            end
        end
    end

    // never accept a beat while a result is pending
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted with result pending");
    // fill counts stay within the depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_new_cnt <= DEPTH_C) && (r_old_cnt <= DEPTH_C))
        else $error("level count beyond depth");
    // a result appears only after the drain state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> $past(r_state == S_DONE))
        else $error("result without completed walk");
    // the merge pointer never passes the old count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_idx <= r_old_cnt)
        else $error("merge pointer past old book");
endmodule

/* rtl/core/obm_ram.sv */
`timescale 1ns / 1ps
module obm_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 512,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/core/obm_mac.sv */
`timescale 1ns / 1ps
module obm_mac
    import obm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_clr,
    input  logic                i_en,
    input  logic [QTY_W-1:0]    i_mult,
    input  logic [PRICE_W-1:0]  i_price,
    output logic [COST_W-1:0]   o_acc
);
    // one multiply registered, then accumulated next cycle
    logic [COST_W-1:0] r_prod;
    logic              r_prod_v;
    logic [COST_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        r_prod   <= COST_W'(i_mult) * COST_W'(i_price);
        r_prod_v <= i_en & ~i_clr;
        if (i_clr) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_acc = r_acc;
endmodule
